// ===== hw/rtl/ofb_pkg.sv =====
// Shared types and constants for the OLED page frame buffer.
package ofb_pkg;

	typedef enum logic [1:0] {
		MODE_POINT   = 2'd0,
		MODE_CLEAR   = 2'd1,
		MODE_FILL    = 2'd2,
		MODE_REFRESH = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Refresh stream: three command bytes per page, then the column data.
	localparam int CMD_COUNT     = 3;
	localparam int POS_PAGE_CMD  = 0;
	localparam int POS_COLHI_CMD = 1;
	localparam int POS_COLLO_CMD = 2;

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] BYTE_CLEAR    = 8'h00;
	localparam logic [7:0] BYTE_FILL     = 8'hFF;

	typedef struct packed {
		logic load;        // transaction accepted: latch item, read memory
		logic sweep_start; // arm the clear or fill sweep
		logic sweep_en;    // write one sweep entry
		logic wr_point;    // write back the modified point byte
		logic emit;        // load the output register with a refresh byte
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/ofb_if.sv =====
// Valid/ready channel interfaces for item requests and refresh bytes.
interface ofb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] x;
	logic [7:0] y;
	logic       color;

	modport source (output valid, mode, x, y, color, input ready);
	modport sink (input valid, mode, x, y, color, output ready);
endinterface

interface ofb_rsp_if;
	logic       valid;
	logic       ready;
	logic       is_command;
	logic [7:0] out_byte;
	logic       frame_end;

	modport source (output valid, is_command, out_byte, frame_end, input ready);
	modport sink (input valid, is_command, out_byte, frame_end, output ready);
endinterface

// ===== hw/rtl/ofb_ctrl.sv =====
// Controller state machine: sequences accept, point update, refresh emit and sweeps.
module ofb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  ofb_pkg::mode_t        in_mode,
	input  ofb_pkg::dp_status_t   status,
	output logic                  in_ready,
	output ofb_pkg::ctrl_cmd_t    cmd
);

	ofb_pkg::state_t state_q, state_d;
	ofb_pkg::mode_t  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ofb_pkg::ST_SWEEP;
			mode_q  <= ofb_pkg::MODE_POINT;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				mode_q <= in_mode;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ofb_pkg::ST_SWEEP: begin
				cmd.sweep_en = 1'b1;
				if (status.sweep_last)
					state_d = ofb_pkg::ST_IDLE;
			end
			ofb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (in_mode) inside
						ofb_pkg::MODE_CLEAR, ofb_pkg::MODE_FILL: begin
							cmd.sweep_start = 1'b1;
							state_d         = ofb_pkg::ST_SWEEP;
						end
						default: state_d = ofb_pkg::ST_EXEC;
					endcase
				end
			end
			ofb_pkg::ST_EXEC: begin
				if (mode_q == ofb_pkg::MODE_REFRESH) begin
					// hold the read byte until the output register frees up
					if (status.out_free) begin
						cmd.emit = 1'b1;
						state_d  = ofb_pkg::ST_IDLE;
					end
				end else begin
					cmd.wr_point = 1'b1;
					state_d      = ofb_pkg::ST_IDLE;
				end
			end
			default: state_d = ofb_pkg::ST_IDLE;
		endcase
	end

	a_no_accept_outside_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == ofb_pkg::ST_IDLE))
		else $error("transaction accepted outside idle");

	a_sweep_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep_en && status.sweep_last) |=> (state_q == ofb_pkg::ST_IDLE))
		else $error("sweep did not end in idle");

	a_exec_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !cmd.sweep_start) |=> (state_q == ofb_pkg::ST_EXEC))
		else $error("point or refresh transaction lost");

endmodule

// ===== hw/rtl/ofb_dp.sv =====
// Datapath: frame memory, fill sweep counter, refresh position and output register.
module ofb_dp #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ofb_pkg::mode_t       in_mode,
	input  logic [7:0]           in_x,
	input  logic [7:0]           in_y,
	input  logic                 in_color,
	input  ofb_pkg::ctrl_cmd_t   cmd,
	output ofb_pkg::dp_status_t  status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_is_command,
	output logic [7:0]           out_byte,
	output logic                 out_frame_end
);

	localparam int MEM = COLUMNS * PAGES;
	localparam int AW  = $clog2(MEM);
	localparam int PGW = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int PSW = $clog2(COLUMNS + ofb_pkg::CMD_COUNT);
	localparam logic [AW-1:0]  PAGES_A  = AW'(PAGES);
	localparam logic [AW-1:0]  MEM_LAST = AW'(MEM - 1);
	localparam logic [PSW-1:0] POS_LAST = PSW'(ofb_pkg::CMD_COUNT + COLUMNS - 1);
	localparam logic [PGW-1:0] PAGE_LAST = PGW'(PAGES - 1);

	logic [7:0]     mem_q [MEM];
	logic [7:0]     rdata_q;
	logic [AW-1:0]  addr_q;
	logic [2:0]     bit_q;
	logic           color_q;
	logic           hit_q;
	logic [AW-1:0]  cnt_q;
	logic           fill_q;
	logic [PSW-1:0] pos_q;
	logic [PGW-1:0] page_q;
	logic           out_valid_q;
	logic           is_command_q;
	logic [7:0]     byte_q;
	logic           frame_end_q;

	logic [AW-1:0]  pt_addr, rf_addr, rd_addr, wr_addr;
	logic [PSW-1:0] col;
	logic           hit;
	logic [7:0]     bit_mask, pt_data, wr_data, emit_byte;
	logic           wr_en, emit_cmd, emit_end;

	// byte for column c, page p sits at c*PAGES + p
	assign hit = ({1'b0, in_x} < 9'(COLUMNS)) && ({1'b0, in_y} < 9'(PAGES * 8));
	assign pt_addr = AW'(in_x) * PAGES_A + AW'(in_y[7:3]);
	assign col = pos_q - PSW'(ofb_pkg::CMD_COUNT);
	assign rf_addr = AW'(col) * PAGES_A + AW'(page_q);
	assign rd_addr = (in_mode == ofb_pkg::MODE_REFRESH) ? rf_addr : pt_addr;

	assign bit_mask = 8'b1 << bit_q;
	assign pt_data  = color_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
	assign wr_en    = cmd.sweep_en || (cmd.wr_point && hit_q);
	assign wr_addr  = cmd.sweep_en ? cnt_q : addr_q;
	assign wr_data  = cmd.sweep_en ? (fill_q ? ofb_pkg::BYTE_FILL : ofb_pkg::BYTE_CLEAR)
	                               : pt_data;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (cmd.load)
			rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q  <= pt_addr;
			bit_q   <= in_y[2:0];
			color_q <= in_color;
			hit_q   <= hit;
		end
	end

	// reset starts a clearing sweep, so the counter and value reset too
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fill_q <= 1'b0;
		end else if (cmd.sweep_start) begin
			cnt_q  <= '0;
			fill_q <= (in_mode == ofb_pkg::MODE_FILL);
		end else if (cmd.sweep_en) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	assign status.sweep_last = (cnt_q == MEM_LAST);
	assign status.out_free   = !out_valid_q || out_ready;

	always_comb begin
		emit_cmd  = 1'b1;
		emit_end  = 1'b0;
		emit_byte = rdata_q;
		if (pos_q == PSW'(ofb_pkg::POS_PAGE_CMD))
			emit_byte = ofb_pkg::CMD_PAGE_BASE + 8'(page_q);
		else if (pos_q == PSW'(ofb_pkg::POS_COLHI_CMD))
			emit_byte = ofb_pkg::CMD_COL_HIGH;
		else if (pos_q == PSW'(ofb_pkg::POS_COLLO_CMD))
			emit_byte = ofb_pkg::CMD_COL_LOW;
		else begin
			emit_cmd = 1'b0;
			emit_end = (pos_q == POS_LAST) && (page_q == PAGE_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			page_q <= '0;
		end else if (cmd.emit) begin
			if (pos_q == POS_LAST) begin
				pos_q  <= '0;
				page_q <= (page_q == PAGE_LAST) ? '0 : page_q + PGW'(1);
			end else begin
				pos_q <= pos_q + PSW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			is_command_q <= emit_cmd;
			byte_q       <= emit_byte;
			frame_end_q  <= emit_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_is_command = is_command_q;
	assign out_byte       = byte_q;
	assign out_frame_end  = frame_end_q;

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sweep_en && cmd.wr_point))
		else $error("sweep and point write collide");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("refresh byte overwrote a pending transaction");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted byte not presented");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= POS_LAST) && (page_q <= PAGE_LAST))
		else $error("refresh position out of range");

endmodule

// ===== hw/rtl/oled_page_framebuffer_core.sv =====
// Top level: page-organized monochrome frame buffer with refresh byte serializer.
// Point draw and refresh step: acceptance reads the frame memory into a register; a point
// draw then writes back the new byte, a refresh step loads the output register once it is
// free, and only then is a new one accepted. Clear and fill: one memory write per cycle.
// Reset (arst_n low) clears control state, then a clearing pass over every byte
// zeroes the frame memory with req.ready held low; the refresh stream restarts at page 0.
module oled_page_framebuffer_core #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	ofb_req_if.sink   req,
	ofb_rsp_if.source rsp
);

	ofb_pkg::ctrl_cmd_t  cmd;
	ofb_pkg::dp_status_t status;
	ofb_pkg::mode_t      mode;

	assign mode = ofb_pkg::mode_t'(req.mode);

	ofb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_mode  (mode),
		.status   (status),
		.in_ready (req.ready),
		.cmd      (cmd)
	);

	ofb_dp #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_mode        (mode),
		.in_x           (req.x),
		.in_y           (req.y),
		.in_color       (req.color),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.out_is_command (rsp.is_command),
		.out_byte       (rsp.out_byte),
		.out_frame_end  (rsp.frame_end)
	);

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the OLED page frame buffer: drawing, sweeps and refresh stream.
module testbench;
	import ofb_pkg::*;

	localparam int COLUMNS    = 128;
	localparam int PAGES      = 4;
	localparam int ROWS       = PAGES * 8;
	localparam int MEM_DEPTH  = COLUMNS * PAGES;
	localparam int PAGE_STEPS = CMD_COUNT + COLUMNS;

	typedef struct packed {
		logic       is_command;
		logic [7:0] out_byte;
		logic       frame_end;
	} panel_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	ofb_req_if req_ch();
	ofb_rsp_if rsp_ch();

	oled_page_framebuffer_core #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the panel memory and refresh stream position
	logic [7:0]  shadow_fb [MEM_DEPTH];
	int          stream_page = 0;
	int          stream_pos  = 0;
	panel_byte_t pending_bytes [$];

	int errors    = 0;
	int n_points  = 0;
	int n_sweeps  = 0;
	int n_refresh = 0;
	int n_frames  = 0;
	bit idle_on   = 1'b0;
	int hold_left = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one accepted transaction to the shadow state; refresh steps queue a panel byte.
	function automatic void predict_panel_bytes(mode_t m, logic [7:0] px, logic [7:0] py,
			logic pc);
		panel_byte_t pb;
		int col;
		int idx;
		case (m)
		MODE_POINT: begin
			n_points++;
			if (px < COLUMNS && py < ROWS) begin
				idx = px * PAGES + py[7:3];
				shadow_fb[idx][py[2:0]] = pc;
			end
		end
		MODE_CLEAR: begin
			n_sweeps++;
			foreach (shadow_fb[i]) shadow_fb[i] = BYTE_CLEAR;
		end
		MODE_FILL: begin
			n_sweeps++;
			foreach (shadow_fb[i]) shadow_fb[i] = BYTE_FILL;
		end
		MODE_REFRESH: begin
			n_refresh++;
			pb = '0;
			case (stream_pos)
			POS_PAGE_CMD: begin
				pb.is_command = 1'b1;
				pb.out_byte   = CMD_PAGE_BASE + 8'(stream_page);
			end
			POS_COLHI_CMD: begin
				pb.is_command = 1'b1;
				pb.out_byte   = CMD_COL_HIGH;
			end
			POS_COLLO_CMD: begin
				pb.is_command = 1'b1;
				pb.out_byte   = CMD_COL_LOW;
			end
			default: begin
				col          = stream_pos - CMD_COUNT;
				pb.out_byte  = shadow_fb[col * PAGES + stream_page];
				pb.frame_end = (col == COLUMNS - 1) && (stream_page == PAGES - 1);
			end
			endcase
			pending_bytes.push_back(pb);
			stream_pos++;
			if (stream_pos == PAGE_STEPS) begin
				stream_pos  = 0;
				stream_page = (stream_page + 1) % PAGES;
			end
		end
		endcase
	endfunction

	// Offer one item, optionally after a random gap; returns at the accepting edge.
	task automatic send_item(mode_t m, logic [7:0] px, logic [7:0] py, logic pc);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode  <= m;
		req_ch.x     <= px;
		req_ch.y     <= py;
		req_ch.color <= pc;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predict_panel_bytes(m, px, py, pc);
	endtask

	// Stop offering and wait until every queued panel byte has come out
	task automatic wait_for_bytes();
		int guard;
		guard = 0;
		req_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_bytes.size() != 0) begin
			$error("%0d refresh bytes never arrived", pending_bytes.size());
			errors++;
		end
	endtask

	// Pixel corners, off-screen points, sweeps in the middle of a page refresh
	task automatic test_directed();
		send_item(MODE_POINT, 0, 0, 1'b1);
		send_item(MODE_POINT, 0, 7, 1'b1);
		send_item(MODE_POINT, 1, 3, 1'b1);
		send_item(MODE_POINT, 1, 3, 1'b0);
		send_item(MODE_POINT, 1, 2, 1'b1);
		send_item(MODE_POINT, 128, 0, 1'b1);
		send_item(MODE_POINT, 0, 32, 1'b1);
		send_item(MODE_POINT, 255, 255, 1'b1);
		send_item(MODE_POINT, 127, 31, 1'b1);
		send_item(MODE_REFRESH, 255, 255, 1'b1);
		send_item(MODE_REFRESH, 0, 0, 1'b0);
		send_item(MODE_REFRESH, 170, 85, 1'b1);
		send_item(MODE_REFRESH, 85, 170, 1'b0);
		send_item(MODE_REFRESH, 0, 0, 1'b0);
		send_item(MODE_FILL, 255, 255, 1'b0);
		send_item(MODE_REFRESH, 0, 0, 1'b0);
		send_item(MODE_POINT, 3, 0, 1'b0);
		send_item(MODE_REFRESH, 0, 0, 1'b0);
		send_item(MODE_CLEAR, 255, 255, 1'b1);
		send_item(MODE_REFRESH, 0, 0, 1'b0);
		send_item(MODE_POINT, 5, 7, 1'b1);
		send_item(MODE_REFRESH, 0, 0, 1'b0);
	endtask

	// Output side stalls long enough for the core to back up into its input
	task automatic test_output_hold();
		hold_left = 300;
		repeat (40) send_item(MODE_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom));
		wait_for_bytes();
	endtask

	// Bursts of drawing followed by refresh runs, with occasional clear or fill
	task automatic test_random_traffic(int n_items);
		int sent;
		int burst;
		logic [7:0] px;
		logic [7:0] py;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 5) == 0) begin
				if ($urandom_range(0, 1))
					send_item(MODE_FILL, 8'($urandom), 8'($urandom), 1'($urandom));
				else
					send_item(MODE_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
				sent++;
			end
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				if ($urandom_range(0, 9) == 0) begin
					px = 8'($urandom);
					py = 8'($urandom);
				end else begin
					px = 8'($urandom_range(0, COLUMNS - 1));
					py = 8'($urandom_range(0, ROWS - 1));
				end
				send_item(MODE_POINT, px, py, 1'($urandom));
			end
			sent += burst;
			burst = $urandom_range(1, 40);
			repeat (burst)
				send_item(MODE_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom));
			sent += burst;
		end
	endtask

	// Receiver: random stall bursts, plus a long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 17);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each panel byte transaction against the oldest prediction
	always @(posedge clk) begin
		panel_byte_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected panel byte: out_byte %02h", rsp_ch.out_byte);
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (rsp_ch.is_command !== want.is_command) begin
					$error("is_command: expected %0d, got %0d", want.is_command,
						rsp_ch.is_command);
					errors++;
				end
				if (rsp_ch.out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte,
						rsp_ch.out_byte);
					errors++;
				end
				if (rsp_ch.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, got %0d", want.frame_end,
						rsp_ch.frame_end);
					errors++;
				end
				if (want.frame_end)
					n_frames++;
			end
		end
	end

	initial begin
		foreach (shadow_fb[i]) shadow_fb[i] = BYTE_CLEAR;
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.mode  <= MODE_POINT;
		req_ch.x     <= '0;
		req_ch.y     <= '0;
		req_ch.color <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n  <= 1'b1;
		idle_on = 1'b1;
		test_directed();
		test_output_hold();
		test_random_traffic(1500);
		// last stretch runs at full rate on both sides
		idle_on = 1'b0;
		test_random_traffic(290);
		wait_for_bytes();
		repeat (20) @(posedge clk);
		$display("Covered %0d point draws, %0d clear/fill sweeps, %0d refresh steps",
			n_points, n_sweeps, n_refresh);
		$display("and %0d complete frames, including a long output hold-off", n_frames);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/ofb_pkg.sv
hw/rtl/ofb_if.sv
hw/rtl/ofb_ctrl.sv
hw/rtl/ofb_dp.sv
hw/rtl/oled_page_framebuffer_core.sv
test/testbench.sv
